// ----- src/assert_macros.svh -----
// Assertion macros shared by the vector similarity score RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low
`define VSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define VSS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/vss_pkg.sv -----
// Package for the vector similarity score block: widths, codes, types.
// No dependencies; the design modules and the request and result interfaces import it.
package vss_pkg;

  localparam int LANES   = 4;
  localparam int ELEM_W  = 16;
  localparam int TERM_W  = 34;
  localparam int ACC_W   = 48;
  localparam int NORM_W  = 32;
  localparam int CNT_W   = 3;
  localparam int LIDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int ROOT_W  = 32;
  localparam int DEN_W   = 64;
  localparam int QUOT_W  = 31;
  localparam int QCNT_W  = $clog2(QUOT_W + 1);
  localparam int SCALE_W = 15;

  localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] Q_POS_MAX = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] Q_NEG_MIN = -ACC_W'(64'sh8000_0000);

  typedef enum logic [1:0] {
    MET_NEG_L2   = 2'd0,
    MET_DOT      = 2'd1,
    MET_COSINE   = 2'd2,
    MET_COS_NORM = 2'd3
  } metric_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MERGE, ST_LAST, ST_FIN, ST_HOLD
  } state_e;

  typedef enum logic [2:0] {
    FS_IDLE, FS_ROOT, FS_MUL, FS_CHECK, FS_DIV, FS_SIGN, FS_DONE
  } fin_state_e;

  typedef struct packed {
    logic                     vld;
    logic signed [TERM_W-1:0] sq;
    logic signed [TERM_W-1:0] ab;
    logic signed [TERM_W-1:0] aa;
    logic signed [TERM_W-1:0] bb;
  } lane_prod_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sq;
    logic signed [ACC_W-1:0] ab;
    logic signed [ACC_W-1:0] aa;
    logic signed [ACC_W-1:0] bb;
    logic                    ovf;
  } acc_t;

  typedef struct packed {
    metric_e                 metric;
    logic signed [ACC_W-1:0] sq;
    logic signed [ACC_W-1:0] ab;
    logic signed [ACC_W-1:0] aa;
    logic signed [ACC_W-1:0] bb;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
  } fin_req_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [ACC_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_add(logic signed [ACC_W-1:0] acc,
                                   logic signed [TERM_W-1:0] term);
    logic signed [ACC_W:0] s;
    sat_t res;
    s = (ACC_W+1)'(acc) + (ACC_W+1)'(term);
    res.ovf = 1'b0;
    res.val = s[ACC_W-1:0];
    if (s > ACC_MAX) begin
      res.ovf = 1'b1;
      res.val = ACC_MAX[ACC_W-1:0];
    end else if (s < ACC_MIN) begin
      res.ovf = 1'b1;
      res.val = ACC_MIN[ACC_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- src/vss_in_if.sv -----
// Input request channel of the vector similarity score block.
// Depends on vss_pkg for widths.
interface vss_in_if;
  import vss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] a_lane0;
  logic signed [ELEM_W-1:0] a_lane1;
  logic signed [ELEM_W-1:0] a_lane2;
  logic signed [ELEM_W-1:0] a_lane3;
  logic signed [ELEM_W-1:0] b_lane0;
  logic signed [ELEM_W-1:0] b_lane1;
  logic signed [ELEM_W-1:0] b_lane2;
  logic signed [ELEM_W-1:0] b_lane3;
  logic [CNT_W-1:0]         lanes_valid;
  logic                     last;
  logic [NORM_W-1:0]        norm_a;
  logic [NORM_W-1:0]        norm_b;

  modport source (output valid, a_lane0, a_lane1, a_lane2, a_lane3, b_lane0, b_lane1,
                  b_lane2, b_lane3, lanes_valid, last, norm_a, norm_b, input ready);
  modport sink (input valid, a_lane0, a_lane1, a_lane2, a_lane3, b_lane0, b_lane1,
                b_lane2, b_lane3, lanes_valid, last, norm_a, norm_b, output ready);
endinterface

// ----- src/vss_out_if.sv -----
// Result channel of the vector similarity score block.
// Depends on vss_pkg for widths.
interface vss_out_if;
  import vss_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] score;
  logic                    saturated;

  modport source (output valid, score, saturated, input ready);
  modport sink (input valid, score, saturated, output ready);
endinterface

// ----- src/vss_cfg_if.sv -----
// Configuration write channel carrying the metric register.
// No dependencies.
interface vss_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] metric;

  modport source (output valid, metric, input ready);
  modport sink (input valid, metric, output ready);
endinterface

// ----- src/vector_similarity_score.sv -----
// Vector similarity score: four lanes accumulate (a-b)^2, a.b, a.a, b.b per vector pair.
// Each request goes into the lane product registers, then one lane per cycle is merged
// into the saturating sums. No request is taken until all lanes are merged and, after a
// last one, the score is loaded. Score pass: L2 and dot go straight out; supplied-norm
// cosine runs multiply, check (zero or overflow skips divide), 31-step divide, sign; cosine roots first.
// Reset (rst_ni low, asynchronous) clears sums, flag, metric, FSMs and result valid.
module vector_similarity_score import vss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vss_in_if.sink      req_i,
  vss_out_if.source   rsp_o,
  vss_cfg_if.sink     cfg_i
);
`include "assert_macros.svh"

  state_e            state_q, state_d;
  logic [LIDX_W-1:0] lane_cnt_q;
  logic              last_q;
  logic [NORM_W-1:0] norm_a_q, norm_b_q;
  metric_e           metric_q;

  logic                    accept, lane_load, merge_step, fin_start, fin_busy, fin_done;
  logic                    out_free, out_load;
  logic                    out_valid_q, sat_q, sat_hold_q;
  logic signed [ACC_W-1:0] score_q, fin_score;

  logic signed [ELEM_W-1:0] a_vec [LANES];
  logic signed [ELEM_W-1:0] b_vec [LANES];
  lane_prod_t               prod  [LANES];
  acc_t                     acc;
  fin_req_t                 fin_req;

  assign accept    = req_i.valid && req_i.ready;
  assign lane_load = accept;
  assign out_free  = !out_valid_q || rsp_o.ready;

  assign a_vec[0] = req_i.a_lane0;
  assign a_vec[1] = req_i.a_lane1;
  assign a_vec[2] = req_i.a_lane2;
  assign a_vec[3] = req_i.a_lane3;
  assign b_vec[0] = req_i.b_lane0;
  assign b_vec[1] = req_i.b_lane1;
  assign b_vec[2] = req_i.b_lane2;
  assign b_vec[3] = req_i.b_lane3;

  // Each lane keeps its own products; lanes past lanes_valid are marked idle
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vss_lane u_lane (
      .clk_i,
      .load_i(lane_load),
      .vld_i (req_i.lanes_valid > CNT_W'(i)),
      .a_i   (a_vec[i]),
      .b_i   (b_vec[i]),
      .prod_o(prod[i])
    );
  end

  // Merge lanes in order, one a cycle, so every addition saturates on its own
  vss_merge u_merge (
    .clk_i, .rst_ni,
    .step_i (merge_step),
    .clear_i(fin_start),
    .prod_i (prod[lane_cnt_q]),
    .acc_o  (acc)
  );

  always_comb begin
    fin_req.metric = metric_q;
    fin_req.sq     = acc.sq;
    fin_req.ab     = acc.ab;
    fin_req.aa     = acc.aa;
    fin_req.bb     = acc.bb;
    fin_req.norm_a = norm_a_q;
    fin_req.norm_b = norm_b_q;
  end

  vss_finish u_finish (
    .clk_i, .rst_ni,
    .start_i(fin_start),
    .req_i  (fin_req),
    .busy_o (fin_busy),
    .done_o (fin_done),
    .score_o(fin_score)
  );

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MERGE;
      ST_MERGE: begin
        if (lane_cnt_q == LIDX_W'(LANES - 1)) begin
          state_d = last_q ? ST_LAST : ST_IDLE;
        end
      end
      ST_LAST:  state_d = ST_FIN;
      ST_FIN:   if (fin_done) state_d = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    merge_step  = (state_q == ST_MERGE);
    fin_start   = (state_q == ST_LAST);
    out_load    = ((state_q == ST_FIN) && fin_done && out_free) ||
                  ((state_q == ST_HOLD) && out_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lane_cnt_q  <= '0;
      last_q      <= 1'b0;
      metric_q    <= MET_NEG_L2;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        lane_cnt_q <= '0;
        last_q     <= req_i.last;
      end else if (merge_step) begin
        lane_cnt_q <= lane_cnt_q + LIDX_W'(1);
      end
      if (cfg_i.valid && cfg_i.ready) begin
        metric_q <= metric_e'(cfg_i.metric);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: norms of the pending request, flag of the vector being scored
  always_ff @(posedge clk_i) begin
    if (accept) begin
      norm_a_q <= req_i.norm_a;
      norm_b_q <= req_i.norm_b;
    end
    if (fin_start) begin
      sat_hold_q <= acc.ovf;
    end
    if (out_load) begin
      score_q <= fin_score;
      sat_q   <= sat_hold_q;
    end
  end

  assign cfg_i.ready     = 1'b1;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.score     = score_q;
  assign rsp_o.saturated = sat_q;

  `VSS_ASSERT(a_accept_fin_idle, accept |-> !fin_busy, "request taken while score unit busy")
  `VSS_ASSERT(a_clear_on_start, fin_start |=> (acc == '0), "sums not cleared after last")
  `VSS_ASSERT(a_load_source, $rose(out_valid_q) |-> ($past(fin_done) || $past(state_q == ST_HOLD)), "result loaded without score")

endmodule

// ----- src/vss_lane.sv -----
// One lane: forms the four products of an element pair and registers them.
// Depends on vss_pkg.
module vss_lane import vss_pkg::*; (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     vld_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic signed [ELEM_W-1:0] b_i,
  output lane_prod_t               prod_o
);

  logic signed [ELEM_W:0] diff;
  lane_prod_t prod_d, prod_q;

  assign diff = (ELEM_W+1)'(a_i) - (ELEM_W+1)'(b_i);

  always_comb begin
    prod_d.vld = vld_i;
    prod_d.sq  = TERM_W'(diff) * TERM_W'(diff);
    prod_d.ab  = TERM_W'(a_i) * TERM_W'(b_i);
    prod_d.aa  = TERM_W'(a_i) * TERM_W'(a_i);
    prod_d.bb  = TERM_W'(b_i) * TERM_W'(b_i);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- src/vss_merge.sv -----
// Merging stage: folds one valid lane's products a cycle, while stepped, into the four saturating sums.
// Depends on vss_pkg.
module vss_merge import vss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       clear_i,
  input  lane_prod_t prod_i,
  output acc_t       acc_o
);

  acc_t acc_d, acc_q;
  sat_t s_sq, s_ab, s_aa, s_bb;

  always_comb begin
    s_sq = sat_add(acc_q.sq, prod_i.sq);
    s_ab = sat_add(acc_q.ab, prod_i.ab);
    s_aa = sat_add(acc_q.aa, prod_i.aa);
    s_bb = sat_add(acc_q.bb, prod_i.bb);
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (step_i && prod_i.vld) begin
      acc_d.sq  = s_sq.val;
      acc_d.ab  = s_ab.val;
      acc_d.aa  = s_aa.val;
      acc_d.bb  = s_bb.val;
      acc_d.ovf = acc_q.ovf | s_sq.ovf | s_ab.ovf | s_aa.ovf | s_bb.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- src/vss_isqrt.sv -----
// Floor square root of a 64-bit value, found one result bit at a time.
// Depends on vss_pkg.
module vss_isqrt import vss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DEN_W-1:0]  x_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [DEN_W-1:0] x_q, r_q, bit_q, trial;
  logic             busy_q;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[1:0] != 2'b00) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      r_q   <= '0;
      bit_q <= {2'b01, {(DEN_W-2){1'b0}}};
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // the final step retires the lowest bit; done is registered and rises in the cycle after it
  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else begin
      fin_q <= busy_q && bit_q[1:0] != 2'b00;
    end
  end

  assign done_o = fin_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

// ----- src/vss_finish.sv -----
// Score unit: picks the metric, forms the cosine denominator and divides.
// Depends on vss_pkg and vss_isqrt.
module vss_finish import vss_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  fin_req_t                req_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] score_o
);

  fin_state_e state_q, state_d;

  logic [ACC_W-1:0]        mag_q;
  logic                    neg_q;
  logic [NORM_W-1:0]       op_a_q, op_b_q;
  logic [DEN_W-1:0]        den_q, rem_q, r0;
  logic [DEN_W:0]          trial;
  logic [QUOT_W-1:0]       quot_q;
  logic [QCNT_W-1:0]       cnt_q;
  logic signed [ACC_W-1:0] score_q;
  logic [ACC_W-1:0]        sq_mag;
  logic                    root_start, root_done_a, root_done_b;
  logic [ROOT_W-1:0]       root_a, root_b;
  logic [DEN_W-1:0]        x_a, x_b;

  assign x_a   = {req_i.aa, 16'h0000};
  assign x_b   = {req_i.bb, 16'h0000};
  assign r0    = {1'b0, mag_q, {SCALE_W{1'b0}}};
  assign trial = {rem_q, 1'b0};
  assign sq_mag = req_i.ab[ACC_W-1] ? ACC_W'(-req_i.ab) : req_i.ab;

  vss_isqrt u_root_a (
    .clk_i, .rst_ni, .start_i(root_start), .x_i(x_a), .done_o(root_done_a), .root_o(root_a)
  );
  vss_isqrt u_root_b (
    .clk_i, .rst_ni, .start_i(root_start), .x_i(x_b), .done_o(root_done_b), .root_o(root_b)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: begin
        if (start_i) begin
          unique case (req_i.metric)
            MET_COSINE:   state_d = FS_ROOT;
            MET_COS_NORM: state_d = FS_MUL;
            default:      state_d = FS_DONE;
          endcase
        end
      end
      // both roots run in lock step
      FS_ROOT:  if (root_done_a && root_done_b) state_d = FS_MUL;
      FS_MUL:   state_d = FS_CHECK;
      FS_CHECK: state_d = (den_q == '0 || r0 >= den_q) ? FS_DONE : FS_DIV;
      FS_DIV:   if (cnt_q == QCNT_W'(1)) state_d = FS_SIGN;
      FS_SIGN:  state_d = FS_DONE;
      FS_DONE:  state_d = FS_IDLE;
      default:  state_d = FS_IDLE;
    endcase
  end

  always_comb begin
    root_start = (state_q == FS_IDLE) && start_i && req_i.metric == MET_COSINE;
    busy_o     = (state_q != FS_IDLE);
    done_o     = (state_q == FS_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FS_IDLE: begin
        if (start_i) begin
          mag_q    <= sq_mag;
          neg_q    <= req_i.ab[ACC_W-1];
          op_a_q   <= req_i.norm_a;
          op_b_q   <= req_i.norm_b;
          score_q  <= (req_i.metric == MET_NEG_L2) ? -req_i.sq : req_i.ab;
        end
      end
      FS_ROOT: begin
        op_a_q <= root_a;
        op_b_q <= root_b;
      end
      FS_MUL: den_q <= DEN_W'(op_a_q) * DEN_W'(op_b_q);
      FS_CHECK: begin
        rem_q  <= r0;
        quot_q <= '0;
        cnt_q  <= QCNT_W'(QUOT_W);
        if (den_q == '0) begin
          score_q <= '0;
        end else if (r0 >= den_q) begin
          score_q <= neg_q ? Q_NEG_MIN : Q_POS_MAX;
        end
      end
      FS_DIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_q  <= DEN_W'(trial - {1'b0, den_q});
          quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= trial[DEN_W-1:0];
          quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - QCNT_W'(1);
      end
      FS_SIGN: score_q <= neg_q ? -ACC_W'(quot_q) : ACC_W'(quot_q);
      default: ;
    endcase
  end

  assign score_o = score_q;

endmodule
